// ===== hw/rtl/cfw_pkg.sv =====
// shared types and constants of the circular fifo with search
`timescale 1ns / 1ps

package cfw_pkg;

  // configuration register
  localparam int unsigned CAP_W        = 7;
  localparam logic        REG_CAPACITY = 1'b0;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_DEQ  = 2'd1,
    FUNC_SRCH = 2'd2
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic        [1:0]  func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic               found;
    logic        [5:0]  position;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic        [6:0]  count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_run;
    logic respond;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_search;
    logic scan_done;
  } dp_sts_t;

endpackage

// ===== hw/rtl/cfw_ram.sv =====
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps

module cfw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== hw/rtl/cfw_ctrl.sv =====
// operation sequencer of the circular fifo with search
`timescale 1ns / 1ps

module cfw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output cfw_pkg::dp_cmd_t  cmd_o,
  input  cfw_pkg::dp_sts_t  sts_i
);

  import cfw_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FETCH = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_search ? S_SCAN : S_FETCH;
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/cfw_dp.sv =====
// pointers, counters, search scan and result register
`timescale 1ns / 1ps

module cfw_dp #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfw_pkg::req_t                req_i,
  input  cfw_pkg::dp_cmd_t             cmd_i,
  output cfw_pkg::dp_sts_t             sts_o,
  input  logic                         cfg_wr_i,
  input  logic [cfw_pkg::CAP_W-1:0]    cfg_cap_i,
  input  logic [cfw_pkg::CAP_W-1:0]    cap_i,
  output logic                         mem_we_o,
  output logic [$clog2(DEPTH)-1:0]     mem_waddr_o,
  output logic [DATA_W-1:0]            mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0]     mem_raddr_a_o,
  input  logic [DATA_W-1:0]            mem_rdata_a_i,
  output logic [$clog2(DEPTH)-1:0]     mem_raddr_b_o,
  input  logic [DATA_W-1:0]            mem_rdata_b_i,
  output logic                         done_o,
  output cfw_pkg::rsp_t                rsp_o
);

  import cfw_pkg::*;

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned VW      = (DATA_W < 32) ? DATA_W : 32;
  localparam int unsigned CAP_MAX = (1 << CAP_W) - 1;
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);

  function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CW-1:0] r;
    if (c == '0) begin
      r = CW'(1);
    end else if (32'(c) > 32'(DEPTH)) begin
      r = CW'(DEPTH);
    end else begin
      r = CW'(c);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                            input logic [CW-1:0] cap);
    logic [AW:0] n;
    n = {1'b0, idx} + (AW + 1)'(1);
    return (n >= (AW + 1)'(cap)) ? '0 : n[AW-1:0];
  endfunction

  function automatic logic [31:0] to_field(input logic [DATA_W-1:0] d);
    logic [31:0] r;
    r         = '0;
    r[VW-1:0] = d[VW-1:0];
    return r;
  endfunction

  logic [1:0]        op_q, op_d;
  logic [DATA_W-1:0] key_q, key_d, key_in;
  logic [AW-1:0]     head_q, head_d, tail_q, tail_d, tail_nx;
  logic [CW-1:0]     count_q, count_d, cap_eff;
  status_e           status_q, status_d;
  logic              found_q, found_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     scan_idx_q, scan_idx_d, cmp_idx_q, cmp_idx_d;
  logic [CW-1:0]     left_q, left_d;
  logic              cmp_valid_q, cmp_valid_d;
  logic              hit, full, enq_ok;
  rsp_t              rsp_q, rsp_d;
  logic              done_q, done_d;

  always_comb begin
    key_in         = '0;
    key_in[VW-1:0] = req_i.value[VW-1:0];
  end

  assign cap_eff = eff_cap(cap_i);
  assign tail_nx = advance(tail_q, cap_eff);
  assign full    = (count_q >= cap_eff);
  assign enq_ok  = (op_q == FUNC_ENQ) && !full;
  assign hit     = cmp_valid_q && (mem_rdata_a_i == key_q);

  assign sts_o.is_search = (op_q == FUNC_SRCH);
  assign sts_o.scan_done = hit || (!cmp_valid_q && (left_q == '0));

  // single write port: new tail slot on enqueue
  assign mem_we_o      = cmd_i.exec && enq_ok;
  assign mem_waddr_o   = tail_nx;
  assign mem_wdata_o   = key_q;
  assign mem_raddr_a_o = cmd_i.scan_run ? scan_idx_q : head_q;
  assign mem_raddr_b_o = tail_q;

  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    status_d    = status_q;
    found_d     = found_q;
    pos_d       = pos_q;
    scan_idx_d  = scan_idx_q;
    cmp_idx_d   = cmp_idx_q;
    left_d      = left_q;
    cmp_valid_d = cmp_valid_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;

    // capacity write empties the queue
    if (cfg_wr_i) begin
      head_d  = '0;
      tail_d  = AW'(eff_cap(cfg_cap_i) - CW'(1));
      count_d = '0;
    end

    if (cmd_i.load) begin
      op_d  = req_i.func;
      key_d = key_in;
    end

    if (cmd_i.exec) begin
      status_d = ST_OK;
      found_d  = 1'b0;
      pos_d    = '0;
      case (op_q)
        FUNC_ENQ: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            tail_d  = tail_nx;
            count_d = count_q + CW'(1);
          end
        end
        FUNC_DEQ: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            head_d  = advance(head_q, cap_eff);
            count_d = count_q - CW'(1);
          end
        end
        FUNC_SRCH: begin
          scan_idx_d  = head_q;
          left_d      = count_q;
          cmp_valid_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // read issued one cycle, compared the next
    if (cmd_i.scan_run) begin
      if (hit) begin
        found_d = 1'b1;
        pos_d   = cmp_idx_q;
      end
      if (left_q != '0) begin
        cmp_valid_d = 1'b1;
        cmp_idx_d   = scan_idx_q;
        scan_idx_d  = advance(scan_idx_q, cap_eff);
        left_d      = left_q - CW'(1);
      end else begin
        cmp_valid_d = 1'b0;
      end
    end

    if (cmd_i.respond) begin
      rsp_d.status     = status_q;
      rsp_d.found      = found_q;
      rsp_d.position   = 6'(pos_q);
      rsp_d.head_value = (count_q != '0) ? to_field(mem_rdata_a_i) : '0;
      rsp_d.tail_value = (count_q != '0) ? to_field(mem_rdata_b_i) : '0;
      rsp_d.count      = 7'(count_q);
      done_d           = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= '0;
      head_q      <= '0;
      tail_q      <= AW'(eff_cap(CAP_RST) - CW'(1));
      count_q     <= '0;
      status_q    <= ST_OK;
      found_q     <= 1'b0;
      left_q      <= '0;
      cmp_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      op_q        <= op_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      status_q    <= status_d;
      found_q     <= found_d;
      left_q      <= left_d;
      cmp_valid_q <= cmp_valid_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    pos_q      <= pos_d;
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    rsp_q      <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_eff)
    else $error("entry count above capacity");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && enq_ok && !cfg_wr_i) |=> count_q == $past(count_q) + CW'(1))
    else $error("enqueue did not grow the count");

  a_done_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.respond))
    else $error("result strobe without response step");

  a_found_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.respond && found_q) |-> (op_q == FUNC_SRCH) && (status_q == ST_OK))
    else $error("hit reported for a non-search operation");

endmodule

// ===== hw/rtl/circular_fifo_with_search_top.sv =====
// top level of the circular fifo with search and its capacity register
`timescale 1ns / 1ps

// channel   | signals                                  | transaction
// ----------+------------------------------------------+-------------------------------------
// request   | start, busy, req_i (func, value)         | taken when start high and busy low
// result    | done_o, rsp_o (status .. count)          | one cycle on done_o, always taken
// config    | psel, penable, pwrite, paddr, pwdata,    | capacity at byte address 0,
//           | prdata, pready                           | written in the apb access cycle
//
// enqueue, dequeue and unknown ops: accept, exec, fetch and respond steps, then the result strobe;
// next request can be taken at the edge that ends the strobe cycle
// search: accept, exec, scan steps until a match or until every stored entry is compared,
// then fetch, respond and the result strobe; the scan reads one slot a cycle
// through a single ram read port, stopping at the first match
// reset empties the queue and clears the count, capacity returns to DEPTH capped at the register maximum;
// slots are not cleared; the result side has no backpressure, so nothing ever stalls inside the block

module circular_fifo_with_search_top #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // request
  input  logic           start,
  output logic           busy,
  input  cfw_pkg::req_t  req_i,
  // result
  output logic           done_o,
  output cfw_pkg::rsp_t  rsp_o,
  // apb configuration
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  import cfw_pkg::*;

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CAP_MAX = (1 << CAP_W) - 1;
  // capacity resets to the full depth, limited by the register width
  localparam logic [CAP_W-1:0] CAP_RST = CAP_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);

  logic [CAP_W-1:0]  cap_q, cap_d;
  logic              cfg_wr;
  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [DATA_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

  // apb: zero wait states, register index from the word address
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign cap_d  = cfg_wr ? pwdata[CAP_W-1:0] : cap_q;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RST;
    end else begin
      cap_q <= cap_d;
    end
  end

  // sequencer: accept, execute, optional scan, slot fetch, respond
  cfw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  // head/tail pointers, count, scan pipeline and result register
  cfw_dp #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_wr_i      (cfg_wr),
    .cfg_cap_i     (pwdata[CAP_W-1:0]),
    .cap_i         (cap_q),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_b_i (mem_rdata_b),
    .done_o        (done_o),
    .rsp_o         (rsp_o)
  );

  // slot storage; port a serves scan and head, port b the tail
  cfw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .rdata_a_o (mem_rdata_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_b_o (mem_rdata_b)
  );

endmodule
